>>> rtl/besd_pkg.sv
// Package for the block energy silence detector.
// Field widths, configuration indexes, reset values, the detector state type and the
// result beat type. No dependencies.
package besd_pkg;

	localparam int ENERGY_W    = 31;
	localparam int HOLD_W      = 24;
	localparam int ELAPSED_W   = 25;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 31;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] CFG_DETECT_ENABLE   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_QUIET_THRESHOLD = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_SAMPLES    = 2'd2;

	localparam logic [ENERGY_W-1:0]  QUIET_THRESHOLD_RST = 31'd107374;
	localparam logic [HOLD_W-1:0]    HOLD_SAMPLES_RST    = 24'd96000;
	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX         = '1;

	// Full scale of a Q.30 mean-square value.
	localparam logic [ENERGY_W-1:0] ENERGY_MAX = 31'h4000_0000;

	typedef enum logic [1:0] {
		ST_LOUD,
		ST_QUIET,
		ST_SILENT
	} det_state_t;

	typedef struct packed {
		logic                block_end;
		logic [ENERGY_W-1:0] energy_level;
		logic                quiet_flag;
		logic                silence_confirmed;
		logic                silence_changed;
	} result_t;

endpackage

>>> rtl/block_energy_silence_detector_top.sv
// Top level of the block energy silence detector.
// Depends on besd_pkg and besd_cdiv.
//
// Takes one signed audio sample per beat and returns one result beat per sample, one
// sample per clock when both sides keep up. Each sample is squared to Q.30 and summed
// over BLOCK_FRAMES samples; at each block end the block mean enters a WINDOW_DEPTH
// window whose average is the smoothed energy, and, with detection enabled, a silence
// state machine compares it to quiet_threshold and times the hangover in samples with a
// saturating counter. Each result passes through one input stage, the square-accumulate
// stage, two stages each for the two constant dividers (block mean and window average)
// and the window stage, then the detector stage into the output register. A skid
// register at the output keeps in_ready a registered signal. Write configuration only
// while no samples are in flight.
module block_energy_silence_detector_top
	import besd_pkg::*;
#(
	parameter int BLOCK_FRAMES = 128,
	parameter int WINDOW_DEPTH = 4,
	parameter int SAMPLE_BITS  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic [CFG_INDEX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          block_end,
	output logic [ENERGY_W-1:0]           energy_level,
	output logic                          quiet_flag,
	output logic                          silence_confirmed,
	output logic                          silence_changed
);

	localparam int BLK_L   = $clog2(BLOCK_FRAMES);
	localparam int SUM_W   = ENERGY_W + BLK_L;
	localparam int POS_W   = (BLOCK_FRAMES > 1) ? BLK_L : 1;
	localparam int WIN_L   = $clog2(WINDOW_DEPTH);
	localparam int ACC_W   = ENERGY_W + WIN_L;
	localparam int SLOT_W  = (WINDOW_DEPTH > 1) ? WIN_L : 1;
	localparam int SQ_BITS = 2 * (SAMPLE_BITS - 1);
	localparam int SQ_UP   = (SQ_BITS < 30) ? (30 - SQ_BITS) : 0;
	localparam int SQ_DOWN = (SQ_BITS > 30) ? (SQ_BITS - 30) : 0;
	localparam int SQ_W    = 2 * SAMPLE_BITS + SQ_UP;

	// Configuration registers.
	logic                detect_enable_q;
	logic [ENERGY_W-1:0] quiet_threshold_q;
	logic [HOLD_W-1:0]   hold_samples_q;

	// Pipeline control.
	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic end_s2, end_s3, end_s4, end_s5, end_s6, end_s7;

	// Square and accumulate.
	logic signed [SAMPLE_BITS-1:0] sample_s1;
	logic [SAMPLE_BITS-1:0]        sample_raw;
	logic [SAMPLE_BITS-1:0]        mag;
	logic [2*SAMPLE_BITS-1:0]      sq_full;
	logic [SQ_W-1:0]               sq_wide;
	logic [ENERGY_W-1:0]           sq_q30;
	logic [SUM_W-1:0]              sum_q;
	logic [SUM_W-1:0]              sum_total;
	logic [SUM_W-1:0]              sum_s2;
	logic [POS_W-1:0]              pos_q;
	logic                          blk_last;

	// Window.
	logic [ENERGY_W-1:0] mean_s4;
	logic [ENERGY_W-1:0] win_q [WINDOW_DEPTH];
	logic [SLOT_W-1:0]   slot_q;
	logic [SLOT_W-1:0]   slot_next;
	logic [ENERGY_W-1:0] old_entry;
	logic [ACC_W-1:0]    acc_q;
	logic [ACC_W-1:0]    acc_next;
	logic [ACC_W-1:0]    acc_s5;

	// Detector.
	logic [ENERGY_W-1:0]  level_s7;
	logic [ENERGY_W-1:0]  level_q;
	logic [ENERGY_W-1:0]  level_next;
	logic [ELAPSED_W-1:0] elapsed_q;
	logic [ELAPSED_W-1:0] elapsed_inc;
	logic [ELAPSED_W-1:0] elapsed_d;
	det_state_t           state_q;
	det_state_t           state_d;
	logic                 run;
	logic                 below;
	logic                 held;
	logic                 produce;
	result_t              result_d;

	// Output register and skid.
	result_t out_q;
	result_t skid_q;
	logic    out_valid_q;
	logic    skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			detect_enable_q   <= 1'b0;
			quiet_threshold_q <= QUIET_THRESHOLD_RST;
			hold_samples_q    <= HOLD_SAMPLES_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				CFG_DETECT_ENABLE:   detect_enable_q   <= cfg_wdata[0];
				CFG_QUIET_THRESHOLD: quiet_threshold_q <= cfg_wdata[ENERGY_W-1:0];
				CFG_HOLD_SAMPLES:    hold_samples_q    <= cfg_wdata[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	// The whole pipeline moves together; it stops only while the skid holds a beat.
	assign adv      = !skid_valid_q;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			v_s6   <= 1'b0;
			v_s7   <= 1'b0;
			end_s2 <= 1'b0;
			end_s3 <= 1'b0;
			end_s4 <= 1'b0;
			end_s5 <= 1'b0;
			end_s6 <= 1'b0;
			end_s7 <= 1'b0;
		end else if (adv) begin
			v_s1   <= in_valid;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			v_s5   <= v_s4;
			v_s6   <= v_s5;
			v_s7   <= v_s6;
			end_s2 <= v_s1 & blk_last;
			end_s3 <= end_s2;
			end_s4 <= end_s3;
			end_s5 <= end_s4;
			end_s6 <= end_s5;
			end_s7 <= end_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sample_s1 <= sample;
		end
	end

	// Magnitude of the most negative code wraps to the right unsigned value.
	assign sample_raw = sample_s1;
	assign mag        = sample_raw[SAMPLE_BITS-1] ? (~sample_raw + 1'b1) : sample_raw;
	assign sq_full    = (2*SAMPLE_BITS)'(mag) * (2*SAMPLE_BITS)'(mag);
	assign sq_wide    = SQ_W'(sq_full) << SQ_UP;
	assign sq_q30     = ENERGY_W'(sq_wide >> SQ_DOWN);
	assign sum_total  = sum_q + SUM_W'(sq_q30);
	assign blk_last   = (pos_q == POS_W'(BLOCK_FRAMES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			pos_q <= '0;
		end else if (adv && v_s1) begin
			if (blk_last) begin
				sum_q <= '0;
				pos_q <= '0;
			end else begin
				sum_q <= sum_total;
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s2 <= sum_total;
		end
	end

	besd_cdiv #(
		.DIVIDEND_W (SUM_W),
		.DIVISOR    (BLOCK_FRAMES)
	) u_mean_div (
		.clk      (clk),
		.en       (adv),
		.dividend (sum_s2),
		.quotient (mean_s4)
	);

	// The window sum is kept running: drop the entry being replaced, add the new mean.
	assign old_entry = win_q[slot_q];
	assign acc_next  = acc_q - ACC_W'(old_entry) + ACC_W'(mean_s4);
	assign slot_next = (slot_q == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q  <= '{default: '0};
			slot_q <= '0;
			acc_q  <= '0;
		end else if (adv && v_s4 && end_s4) begin
			win_q[slot_q] <= mean_s4;
			slot_q        <= slot_next;
			acc_q         <= acc_next;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			acc_s5 <= acc_next;
		end
	end

	besd_cdiv #(
		.DIVIDEND_W (ACC_W),
		.DIVISOR    (WINDOW_DEPTH)
	) u_level_div (
		.clk      (clk),
		.en       (adv),
		.dividend (acc_s5),
		.quotient (level_s7)
	);

	// The hangover counter includes the current sample and runs while detection is off.
	assign elapsed_inc = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + 1'b1;
	assign level_next  = end_s7 ? level_s7 : level_q;
	assign run         = end_s7 & detect_enable_q;
	assign below       = (level_next < quiet_threshold_q);
	assign held        = (elapsed_inc >= ELAPSED_W'(hold_samples_q));

	always_comb begin
		state_d   = state_q;
		elapsed_d = elapsed_inc;
		if (run) begin
			case (state_q)
				ST_LOUD: begin
					if (below) begin
						state_d   = ST_QUIET;
						elapsed_d = '0;
					end
				end
				ST_QUIET: begin
					if (below) begin
						if (held) begin
							state_d = ST_SILENT;
						end
					end else if (!held) begin
						state_d   = ST_LOUD;
						elapsed_d = '0;
					end
				end
				ST_SILENT: begin
					if (!below) begin
						state_d = ST_LOUD;
						if (!held) begin
							elapsed_d = '0;
						end
					end
				end
				default: begin
					state_d = ST_QUIET;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_QUIET;
			elapsed_q <= ELAPSED_MAX;
			level_q   <= '0;
		end else if (adv && v_s7) begin
			state_q   <= state_d;
			elapsed_q <= elapsed_d;
			level_q   <= level_next;
		end
	end

	assign produce = adv & v_s7;

	always_comb begin
		result_d.block_end         = end_s7;
		result_d.energy_level      = level_next;
		result_d.quiet_flag        = (state_d != ST_LOUD);
		result_d.silence_confirmed = (state_d == ST_SILENT);
		result_d.silence_changed   = ((state_q == ST_SILENT) != (state_d == ST_SILENT));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q  <= skid_valid_q | produce;
			skid_valid_q <= 1'b0;
		end else if (produce) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (produce) begin
				out_q <= result_d;
			end
		end else if (produce) begin
			skid_q <= result_d;
		end
	end

	assign out_valid         = out_valid_q;
	assign block_end         = out_q.block_end;
	assign energy_level      = out_q.energy_level;
	assign quiet_flag        = out_q.quiet_flag;
	assign silence_confirmed = out_q.silence_confirmed;
	assign silence_changed   = out_q.silence_changed;

endmodule

>>> rtl/besd_cdiv.sv
// Pipelined division by a constant for the silence detector.
// Multiplies by a scaled reciprocal, split into four partial products; depends on besd_pkg.
module besd_cdiv
	import besd_pkg::*;
#(
	parameter int DIVIDEND_W = 38,
	parameter int DIVISOR    = 128
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [DIVIDEND_W-1:0] dividend,
	output logic [ENERGY_W-1:0]   quotient
);

	localparam int SHIFT_L = $clog2(DIVISOR);
	localparam int SHIFT   = DIVIDEND_W + SHIFT_L;
	localparam int MULT_W  = DIVIDEND_W + 2;
	localparam int HALF_W  = (MULT_W + 1) / 2;
	localparam int PROD_W  = 4 * HALF_W;

	// The ceiling reciprocal gives an exact floor quotient for any dividend below
	// 2**DIVIDEND_W.
	localparam logic [63:0] MULT_FULL =
		((64'd1 << SHIFT) + 64'(DIVISOR - 1)) / 64'(DIVISOR);
	localparam logic [2*HALF_W-1:0] MULT   = (2*HALF_W)'(MULT_FULL);
	localparam logic [HALF_W-1:0]   MULT_LO = MULT[HALF_W-1:0];
	localparam logic [HALF_W-1:0]   MULT_HI = MULT[2*HALF_W-1:HALF_W];

	logic [2*HALF_W-1:0] dividend_ext;
	logic [HALF_W-1:0]   div_lo;
	logic [HALF_W-1:0]   div_hi;
	logic [2*HALF_W-1:0] pp_ll_s1;
	logic [2*HALF_W-1:0] pp_lh_s1;
	logic [2*HALF_W-1:0] pp_hl_s1;
	logic [2*HALF_W-1:0] pp_hh_s1;
	logic [PROD_W-1:0]   product;
	logic [ENERGY_W-1:0] quotient_s2;

	assign dividend_ext = (2*HALF_W)'(dividend);
	assign div_lo       = dividend_ext[HALF_W-1:0];
	assign div_hi       = dividend_ext[2*HALF_W-1:HALF_W];

	always_ff @(posedge clk) begin
		if (en) begin
			pp_ll_s1 <= (2*HALF_W)'(div_lo) * (2*HALF_W)'(MULT_LO);
			pp_lh_s1 <= (2*HALF_W)'(div_lo) * (2*HALF_W)'(MULT_HI);
			pp_hl_s1 <= (2*HALF_W)'(div_hi) * (2*HALF_W)'(MULT_LO);
			pp_hh_s1 <= (2*HALF_W)'(div_hi) * (2*HALF_W)'(MULT_HI);
		end
	end

	assign product = (PROD_W'(pp_hh_s1) << (2*HALF_W))
		+ (PROD_W'(pp_lh_s1) << HALF_W)
		+ (PROD_W'(pp_hl_s1) << HALF_W)
		+ PROD_W'(pp_ll_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			quotient_s2 <= ENERGY_W'(product >> SHIFT);
		end
	end

	assign quotient = quotient_s2;

endmodule

>>> rtl/besd_checker.sv
// Port-level checker for the block energy silence detector, with its bind statement.
// Depends on besd_pkg and block_energy_silence_detector_top.
module besd_checker
	import besd_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input logic                block_end,
	input logic [ENERGY_W-1:0] energy_level,
	input logic                quiet_flag,
	input logic                silence_confirmed,
	input logic                silence_changed
);

	// Confirmed silence can only start or end on a beat that closes a block.
	a_change_at_block_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && silence_changed |-> block_end)
		else $error("silence_changed on a beat that did not close a block");

	// Confirmed silence is always also quiet.
	a_confirmed_is_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && silence_confirmed |-> quiet_flag)
		else $error("silence_confirmed without quiet_flag");

	// A mean of Q.30 squares never exceeds full scale.
	a_energy_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> energy_level <= ENERGY_MAX)
		else $error("energy_level above full scale");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(energy_level)
			&& $stable(quiet_flag) && $stable(silence_confirmed))
		else $error("result beat changed while stalled");

endmodule

bind block_energy_silence_detector_top besd_checker u_besd_checker (.*);
